// ===== rtl/core/qrm_pkg.sv =====
// Shared types, constants and helpers for the quaternion to rotation matrix decoder.
// Depends on nothing; the top level, the product stage and the checker import it.
package qrm_pkg;

   localparam int unsigned QRM_LATENCY = 4;

   localparam logic signed [16:0] QUAT_BIAS  = 17'sd32766;
   // 16383 squared: the unit value of a rotation entry.
   localparam logic signed [33:0] ROT_UNIT   = 34'sd268402689;
   localparam logic        [15:0] TRANS_FLIP = 16'h8000;

   typedef logic signed [16:0] offset_type;
   typedef logic signed [31:0] prod_type;
   typedef logic signed [32:0] sum_type;

   typedef struct packed {
      offset_type dw;
      offset_type dx;
      offset_type dy;
      offset_type dz;
   } quat_off_type;

   typedef struct packed {
      prod_type xx;
      prod_type yy;
      prod_type zz;
      prod_type xy;
      prod_type xz;
      prod_type yz;
      prod_type wx;
      prod_type wy;
      prod_type wz;
   } quat_prod_type;

   // Offsets lie in -32766..32769, so every product fits 32 bits signed.
   function automatic prod_type off_mul(input offset_type a, input offset_type b);
      logic signed [33:0] full;
      full = a * b;
      return full[31:0];
   endfunction

endpackage

// ===== rtl/core/qrm_mul_stage.sv =====
// Product stage of the decoder: the nine pairwise products of the quaternion offsets.
// Depends on qrm_pkg.
module qrm_mul_stage import qrm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          off_valid,
   input  quat_off_type  off,
   output logic          prod_valid,
   output quat_prod_type prod
);

   logic          valid_ff;
   quat_prod_type prod_ff;
   quat_prod_type prod_in;

   always_comb begin
      prod_in.xx = off_mul(off.dx, off.dx);
      prod_in.yy = off_mul(off.dy, off.dy);
      prod_in.zz = off_mul(off.dz, off.dz);
      prod_in.xy = off_mul(off.dx, off.dy);
      prod_in.xz = off_mul(off.dx, off.dz);
      prod_in.yz = off_mul(off.dy, off.dz);
      prod_in.wx = off_mul(off.dw, off.dx);
      prod_in.wy = off_mul(off.dw, off.dy);
      prod_in.wz = off_mul(off.dw, off.dz);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= off_valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod_valid = valid_ff;
   assign prod       = prod_ff;

endmodule

// ===== rtl/core/quat_to_rotation_matrix_decode.sv =====
// A word accepted at a clock edge passes the stage registers to the rsp_ ports and is
// strobed by rsp_valid for exactly one cycle. Throughput: one word every cycle outside reset.
// The pipeline is offsets, products, pairwise sums, then doubling and output register.
// busy is high only while reset is held; the pipeline never stalls.
// Reset (synchronous, active high) clears the stage valid bits; data registers keep
// whatever they hold.
module quat_to_rotation_matrix_decode import qrm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic        [15:0] req_quat_w_raw,
   input  logic        [15:0] req_quat_x_raw,
   input  logic        [15:0] req_quat_y_raw,
   input  logic        [15:0] req_quat_z_raw,
   input  logic        [15:0] req_trans_x_raw,
   input  logic        [15:0] req_trans_y_raw,
   input  logic        [15:0] req_trans_z_raw,
   output logic               rsp_valid,
   output logic signed [32:0] rsp_rot_00,
   output logic signed [33:0] rsp_rot_01,
   output logic signed [33:0] rsp_rot_02,
   output logic signed [33:0] rsp_rot_10,
   output logic signed [32:0] rsp_rot_11,
   output logic signed [33:0] rsp_rot_12,
   output logic signed [33:0] rsp_rot_20,
   output logic signed [33:0] rsp_rot_21,
   output logic signed [32:0] rsp_rot_22,
   output logic signed [15:0] rsp_trans_x,
   output logic signed [15:0] rsp_trans_y,
   output logic signed [15:0] rsp_trans_z
);

   // The block holds off new words only while in reset.
   logic accept;
   assign busy   = reset;
   assign accept = start & ~busy;

   // Stage 1: quaternion offsets d = raw - 32766 and translation words re-biased.
   // Subtracting 32768 from a 16-bit word is the same as flipping its top bit.
   logic              s1_valid_ff;
   quat_off_type      s1_off_ff;
   quat_off_type      s1_off_in;
   logic signed [15:0] s1_tx_ff, s1_ty_ff, s1_tz_ff;

   always_comb begin
      s1_off_in.dw = $signed({1'b0, req_quat_w_raw}) - QUAT_BIAS;
      s1_off_in.dx = $signed({1'b0, req_quat_x_raw}) - QUAT_BIAS;
      s1_off_in.dy = $signed({1'b0, req_quat_y_raw}) - QUAT_BIAS;
      s1_off_in.dz = $signed({1'b0, req_quat_z_raw}) - QUAT_BIAS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_off_ff <= s1_off_in;
      s1_tx_ff  <= $signed(req_trans_x_raw ^ TRANS_FLIP);
      s1_ty_ff  <= $signed(req_trans_y_raw ^ TRANS_FLIP);
      s1_tz_ff  <= $signed(req_trans_z_raw ^ TRANS_FLIP);
   end

   // Stage 2: nine 17x17 products, registered inside the product stage.
   logic          s2_valid;
   quat_prod_type s2_prod;
   logic signed [15:0] s2_tx_ff, s2_ty_ff, s2_tz_ff;

   qrm_mul_stage u_mul (
      .clock      (clock),
      .reset      (reset),
      .off_valid  (s1_valid_ff),
      .off        (s1_off_ff),
      .prod_valid (s2_valid),
      .prod       (s2_prod)
   );

   always_ff @(posedge clock) begin
      s2_tx_ff <= s1_tx_ff;
      s2_ty_ff <= s1_ty_ff;
      s2_tz_ff <= s1_tz_ff;
   end

   // Stage 3: pairwise sums and differences. Each product fits 32 bits, so one more
   // bit holds any sum of two.
   logic    s3_valid_ff;
   sum_type s3_yyzz_ff, s3_xxzz_ff, s3_xxyy_ff;
   sum_type s3_01_ff, s3_02_ff, s3_10_ff, s3_12_ff, s3_20_ff, s3_21_ff;
   logic signed [15:0] s3_tx_ff, s3_ty_ff, s3_tz_ff;

   function automatic sum_type ext(input prod_type p);
      return {p[31], p};
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid;
      end
   end

   always_ff @(posedge clock) begin
      s3_yyzz_ff <= ext(s2_prod.yy) + ext(s2_prod.zz);
      s3_xxzz_ff <= ext(s2_prod.xx) + ext(s2_prod.zz);
      s3_xxyy_ff <= ext(s2_prod.xx) + ext(s2_prod.yy);
      s3_01_ff   <= ext(s2_prod.xy) - ext(s2_prod.wz);
      s3_02_ff   <= ext(s2_prod.xz) + ext(s2_prod.wy);
      s3_10_ff   <= ext(s2_prod.xy) + ext(s2_prod.wz);
      s3_12_ff   <= ext(s2_prod.yz) - ext(s2_prod.wx);
      s3_20_ff   <= ext(s2_prod.xz) - ext(s2_prod.wy);
      s3_21_ff   <= ext(s2_prod.yz) + ext(s2_prod.wx);
      s3_tx_ff   <= s2_tx_ff;
      s3_ty_ff   <= s2_ty_ff;
      s3_tz_ff   <= s2_tz_ff;
   end

   // Stage 4: doubling is a one-bit shift. The diagonal subtracts the doubled sum of
   // squares from the unit value; the result always fits 33 bits, so the top bit of
   // the 34-bit difference is dropped.
   logic               out_valid_ff;
   logic signed [32:0] rot_00_ff, rot_11_ff, rot_22_ff;
   logic signed [33:0] rot_01_ff, rot_02_ff, rot_10_ff, rot_12_ff, rot_20_ff, rot_21_ff;
   logic signed [15:0] out_tx_ff, out_ty_ff, out_tz_ff;
   logic signed [33:0] diag_00_in, diag_11_in, diag_22_in;

   always_comb begin
      diag_00_in = ROT_UNIT - $signed({s3_yyzz_ff, 1'b0});
      diag_11_in = ROT_UNIT - $signed({s3_xxzz_ff, 1'b0});
      diag_22_in = ROT_UNIT - $signed({s3_xxyy_ff, 1'b0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rot_00_ff <= diag_00_in[32:0];
      rot_11_ff <= diag_11_in[32:0];
      rot_22_ff <= diag_22_in[32:0];
      rot_01_ff <= $signed({s3_01_ff, 1'b0});
      rot_02_ff <= $signed({s3_02_ff, 1'b0});
      rot_10_ff <= $signed({s3_10_ff, 1'b0});
      rot_12_ff <= $signed({s3_12_ff, 1'b0});
      rot_20_ff <= $signed({s3_20_ff, 1'b0});
      rot_21_ff <= $signed({s3_21_ff, 1'b0});
      out_tx_ff <= s3_tx_ff;
      out_ty_ff <= s3_ty_ff;
      out_tz_ff <= s3_tz_ff;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_rot_00  = rot_00_ff;
   assign rsp_rot_01  = rot_01_ff;
   assign rsp_rot_02  = rot_02_ff;
   assign rsp_rot_10  = rot_10_ff;
   assign rsp_rot_11  = rot_11_ff;
   assign rsp_rot_12  = rot_12_ff;
   assign rsp_rot_20  = rot_20_ff;
   assign rsp_rot_21  = rot_21_ff;
   assign rsp_rot_22  = rot_22_ff;
   assign rsp_trans_x = out_tx_ff;
   assign rsp_trans_y = out_ty_ff;
   assign rsp_trans_z = out_tz_ff;

endmodule

// ===== rtl/core/qrm_checker.sv =====
// Port-level checker for the decoder, bound to the top level.
// Depends on qrm_pkg and quat_to_rotation_matrix_decode.
module qrm_checker import qrm_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic        [15:0] req_trans_x_raw,
   input logic               rsp_valid,
   input logic signed [32:0] rsp_rot_00,
   input logic signed [15:0] rsp_trans_x
);

   // Every accepted word comes out after the fixed latency.
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##QRM_LATENCY rsp_valid)
      else $error("accepted word did not produce a result on time");

   // No result appears without a word accepted the latency earlier.
   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, QRM_LATENCY))
      else $error("result without a matching accepted word");

   // The translation travels with its quaternion.
   a_trans_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ($unsigned(rsp_trans_x) == ($past(req_trans_x_raw, QRM_LATENCY) ^ TRANS_FLIP)))
      else $error("translation out of step with rotation");

   // The first diagonal entry, rot_00, never exceeds the unit value.
   a_diag_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_rot_00 <= $signed(ROT_UNIT[32:0])))
      else $error("diagonal entry above unit value");

endmodule

bind quat_to_rotation_matrix_decode qrm_checker u_qrm_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_trans_x_raw (req_trans_x_raw),
   .rsp_valid       (rsp_valid),
   .rsp_rot_00      (rsp_rot_00),
   .rsp_trans_x     (rsp_trans_x)
);

// ===== sim/qrm_checker.sv =====
// Checker for the quaternion to rotation matrix decoder: predicts every decoded word
// and compares it, field by field, with what the rsp_ ports strobe out.
// Depends on qrm_pkg for the bias and unit constants.
module qrm_scoreboard import qrm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic        [15:0] req_quat_w_raw,
   input  logic        [15:0] req_quat_x_raw,
   input  logic        [15:0] req_quat_y_raw,
   input  logic        [15:0] req_quat_z_raw,
   input  logic        [15:0] req_trans_x_raw,
   input  logic        [15:0] req_trans_y_raw,
   input  logic        [15:0] req_trans_z_raw,
   input  logic               rsp_valid,
   input  logic signed [32:0] rsp_rot_00,
   input  logic signed [33:0] rsp_rot_01,
   input  logic signed [33:0] rsp_rot_02,
   input  logic signed [33:0] rsp_rot_10,
   input  logic signed [32:0] rsp_rot_11,
   input  logic signed [33:0] rsp_rot_12,
   input  logic signed [33:0] rsp_rot_20,
   input  logic signed [33:0] rsp_rot_21,
   input  logic signed [32:0] rsp_rot_22,
   input  logic signed [15:0] rsp_trans_x,
   input  logic signed [15:0] rsp_trans_y,
   input  logic signed [15:0] rsp_trans_z,
   output int unsigned        fault_count,
   output int unsigned        words_outstanding,
   output int unsigned        words_checked
);

   typedef struct packed {
      logic signed [32:0] rot_00;
      logic signed [33:0] rot_01;
      logic signed [33:0] rot_02;
      logic signed [33:0] rot_10;
      logic signed [32:0] rot_11;
      logic signed [33:0] rot_12;
      logic signed [33:0] rot_20;
      logic signed [33:0] rot_21;
      logic signed [32:0] rot_22;
      logic signed [15:0] trans_x;
      logic signed [15:0] trans_y;
      logic signed [15:0] trans_z;
   } bone_pose_type;

   bone_pose_type expected_poses [$];

   // Exact integer rotation, scaled by 16383 squared, from the four quaternion offsets.
   function automatic bone_pose_type decode_bone(input logic [15:0] qw, qx, qy, qz,
                                                 input logic [15:0] tx, ty, tz);
      longint dw, dx, dy, dz;
      bone_pose_type p;
      dw = longint'(qw) - longint'(QUAT_BIAS);
      dx = longint'(qx) - longint'(QUAT_BIAS);
      dy = longint'(qy) - longint'(QUAT_BIAS);
      dz = longint'(qz) - longint'(QUAT_BIAS);
      p.rot_00 = 33'(longint'(ROT_UNIT) - 2 * (dy * dy + dz * dz));
      p.rot_01 = 34'(2 * (dx * dy - dw * dz));
      p.rot_02 = 34'(2 * (dx * dz + dw * dy));
      p.rot_10 = 34'(2 * (dx * dy + dw * dz));
      p.rot_11 = 33'(longint'(ROT_UNIT) - 2 * (dx * dx + dz * dz));
      p.rot_12 = 34'(2 * (dy * dz - dw * dx));
      p.rot_20 = 34'(2 * (dx * dz - dw * dy));
      p.rot_21 = 34'(2 * (dy * dz + dw * dx));
      p.rot_22 = 33'(longint'(ROT_UNIT) - 2 * (dx * dx + dy * dy));
      p.trans_x = 16'(longint'(tx) - longint'(TRANS_FLIP));
      p.trans_y = 16'(longint'(ty) - longint'(TRANS_FLIP));
      p.trans_z = 16'(longint'(tz) - longint'(TRANS_FLIP));
      return p;
   endfunction

   task automatic compare_field(input string name, input logic signed [63:0] want, got);
      if (got !== want) begin
         fault_count++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      bone_pose_type want;
      if (!reset) begin
         if (rsp_valid !== 1'b0 && rsp_valid !== 1'b1) begin
            fault_count++;
            $display("%0t: rsp_valid is unknown", $time);
         end else if (rsp_valid) begin
            if (expected_poses.size() == 0) begin
               fault_count++;
               $display("%0t: result strobed with no word outstanding", $time);
            end else begin
               want = expected_poses.pop_front();
               compare_field("rot_00", want.rot_00, rsp_rot_00);
               compare_field("rot_01", want.rot_01, rsp_rot_01);
               compare_field("rot_02", want.rot_02, rsp_rot_02);
               compare_field("rot_10", want.rot_10, rsp_rot_10);
               compare_field("rot_11", want.rot_11, rsp_rot_11);
               compare_field("rot_12", want.rot_12, rsp_rot_12);
               compare_field("rot_20", want.rot_20, rsp_rot_20);
               compare_field("rot_21", want.rot_21, rsp_rot_21);
               compare_field("rot_22", want.rot_22, rsp_rot_22);
               compare_field("trans_x", want.trans_x, rsp_trans_x);
               compare_field("trans_y", want.trans_y, rsp_trans_y);
               compare_field("trans_z", want.trans_z, rsp_trans_z);
               words_checked++;
            end
         end
         if (start === 1'b1 && busy === 1'b0)
            expected_poses.push_back(decode_bone(req_quat_w_raw, req_quat_x_raw,
                                                 req_quat_y_raw, req_quat_z_raw,
                                                 req_trans_x_raw, req_trans_y_raw,
                                                 req_trans_z_raw));
         words_outstanding = expected_poses.size();
      end
   end

endmodule

// ===== sim/tb_top.sv =====
// Top of the decoder testbench: clock, reset, bone-word stimulus and the final verdict.
// Depends on qrm_pkg, the decoder RTL and qrm_scoreboard, which does the checking behind the verdict.
module tb_top import qrm_pkg::*;;

   // Number of random words sent after the directed corner cases.
   localparam int unsigned RANDOM_WORDS = 1250;
   // Extra cycles allowed for stragglers once the stimulus is done.
   localparam int unsigned DRAIN_LIMIT = 64;

   // How the quaternion words of one random bone word are drawn.
   typedef enum {PICK_UNIFORM, PICK_NEAR_UNIT, PICK_CORNER} word_mix_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic        [15:0] req_quat_w_raw;
   logic        [15:0] req_quat_x_raw;
   logic        [15:0] req_quat_y_raw;
   logic        [15:0] req_quat_z_raw;
   logic        [15:0] req_trans_x_raw;
   logic        [15:0] req_trans_y_raw;
   logic        [15:0] req_trans_z_raw;
   logic               rsp_valid;
   logic signed [32:0] rsp_rot_00;
   logic signed [33:0] rsp_rot_01;
   logic signed [33:0] rsp_rot_02;
   logic signed [33:0] rsp_rot_10;
   logic signed [32:0] rsp_rot_11;
   logic signed [33:0] rsp_rot_12;
   logic signed [33:0] rsp_rot_20;
   logic signed [33:0] rsp_rot_21;
   logic signed [32:0] rsp_rot_22;
   logic signed [15:0] rsp_trans_x;
   logic signed [15:0] rsp_trans_y;
   logic signed [15:0] rsp_trans_z;

   int unsigned fault_count;
   int unsigned words_outstanding;
   int unsigned words_checked;
   int unsigned words_sent;

   // Quaternion codes around the interesting points: both ends of the range, the zero
   // offset and its neighbors, and plus or minus one unit (16383 away from 32766).
   logic [15:0] quat_corners [9] = '{16'd0, 16'd1, 16'd16383, 16'd32765, 16'd32766,
                                     16'd32767, 16'd49149, 16'd65534, 16'd65535};
   // Translation codes: the ends of the range and both sides of zero.
   logic [15:0] trans_corners [5] = '{16'd0, 16'd1, 16'd32767, 16'd32768, 16'd65535};

   quat_to_rotation_matrix_decode i_dut (.*);

   qrm_scoreboard i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Safety net: even the slowest legal run finishes far inside this window.
   initial begin
      #2000000;
      $display("Timeout: decoder stopped making progress.");
      $display("CHECK FAILED");
      $finish;
   end

   // Presents one bone word and holds it until the decoder takes it. Acceptance is seen
   // at the edge where start is high and busy is low; busy is read right after the edge,
   // so it still holds the value the decoder used at that edge.
   task automatic send_bone(input logic [15:0] qw, qx, qy, qz, tx, ty, tz);
      start           <= 1'b1;
      req_quat_w_raw  <= qw;
      req_quat_x_raw  <= qx;
      req_quat_y_raw  <= qy;
      req_quat_z_raw  <= qz;
      req_trans_x_raw <= tx;
      req_trans_y_raw <= ty;
      req_trans_z_raw <= tz;
      do @(posedge clock); while (busy !== 1'b0);
      words_sent++;
   endtask

   function automatic logic [15:0] pick_quat(input word_mix_type mix);
      case (mix)
         PICK_UNIFORM: begin
            return 16'($urandom_range(0, 65535));
         end
         // Offsets within one unit of zero, the range real rotations live in.
         PICK_NEAR_UNIT: begin
            return 16'($urandom_range(16383, 49149));
         end
         default: begin
            return quat_corners[$urandom_range(0, 8)];
         end
      endcase
   endfunction

   function automatic logic [15:0] pick_trans();
      if ($urandom_range(0, 3) == 0)
         return trans_corners[$urandom_range(0, 4)];
      return 16'($urandom_range(0, 65535));
   endfunction

   initial begin
      int unsigned  directed_count;
      int unsigned  burst;
      int unsigned  drain;
      int unsigned  i;
      word_mix_type mix;

      // Every input is known from time zero; reset is held only once, at the start.
      reset           <= 1'b1;
      start           <= 1'b0;
      req_quat_w_raw  <= '0;
      req_quat_x_raw  <= '0;
      req_quat_y_raw  <= '0;
      req_quat_z_raw  <= '0;
      req_trans_x_raw <= '0;
      req_trans_y_raw <= '0;
      req_trans_z_raw <= '0;
      words_sent = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed words, sent back to back so the pipeline runs full with no bubbles.
      // Both ends of the quaternion range, where every offset is at its extreme.
      send_bone(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_bone(16'd65535, 16'd65535, 16'd65535, 16'd65535,
                16'd65535, 16'd65535, 16'd65535);
      // Zero quaternion gives K on the diagonal and zero elsewhere; zero translation.
      send_bone(16'd32766, 16'd32766, 16'd32766, 16'd32766,
                16'd32768, 16'd32768, 16'd32768);
      // Identity rotation, then half turns about each axis, then the negated identity.
      send_bone(16'd49149, 16'd32766, 16'd32766, 16'd32766,
                16'd32767, 16'd32767, 16'd32767);
      send_bone(16'd32766, 16'd49149, 16'd32766, 16'd32766,
                16'd1, 16'd32769, 16'd65534);
      send_bone(16'd32766, 16'd32766, 16'd49149, 16'd32766,
                16'd65534, 16'd1, 16'd32769);
      send_bone(16'd32766, 16'd32766, 16'd32766, 16'd49149,
                16'd32769, 16'd65534, 16'd1);
      send_bone(16'd16383, 16'd32766, 16'd32766, 16'd32766,
                16'd0, 16'd65535, 16'd32768);
      // Mixed-sign extremes push the off-diagonal sums to their largest magnitudes
      // and the diagonal to its most negative value.
      send_bone(16'd0, 16'd65535, 16'd65535, 16'd65535,
                16'd65535, 16'd0, 16'd32767);
      send_bone(16'd65535, 16'd0, 16'd65535, 16'd0,
                16'd32768, 16'd32767, 16'd0);
      send_bone(16'd0, 16'd65535, 16'd0, 16'd65535,
                16'd32767, 16'd32768, 16'd65535);
      send_bone(16'd65535, 16'd0, 16'd0, 16'd65535,
                16'd1, 16'd65534, 16'd32768);
      // A 90 degree turn about z, roughly, as a typical well-formed quaternion.
      send_bone(16'd44351, 16'd32766, 16'd32766, 16'd44351,
                16'd33408, 16'd32128, 16'd40000);
      // Alternating bit patterns, in both phases, on every field.
      send_bone(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
      send_bone(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
      // Neighbors of the zero offset and of the range ends.
      send_bone(16'd1, 16'd65534, 16'd32767, 16'd32765,
                16'd32767, 16'd32769, 16'd1);
      directed_count = words_sent;

      // Random words in bursts. A burst is sometimes followed straight by the next one,
      // so stretches without idling occur; otherwise start drops for a few cycles, which
      // puts bubbles at every depth of the four-stage pipeline.
      while (words_sent < directed_count + RANDOM_WORDS) begin
         burst = $urandom_range(1, 24);
         for (i = 0; i < burst; i++) begin
            mix = word_mix_type'($urandom_range(0, 2));
            send_bone(pick_quat(mix), pick_quat(mix), pick_quat(mix), pick_quat(mix),
                      pick_trans(), pick_trans(), pick_trans());
         end
         if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
      end
      start <= 1'b0;

      // Let the pipeline empty, then watch a few more cycles for stray strobes.
      for (drain = 0; drain < DRAIN_LIMIT && words_outstanding != 0; drain++)
         @(posedge clock);
      repeat (QRM_LATENCY + 4) @(posedge clock);

      $display("Sent %0d bone words (%0d directed, the rest random in bursts).",
               words_sent, directed_count);
      $display("Checked %0d decoded results; %0d field mismatches, %0d never arrived.",
               words_checked, fault_count, words_outstanding);
      if (fault_count == 0 && words_outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
